// ----- src/cpi_pkg.sv -----
package cpi_pkg;

  // Control that travels beside every transaction down the chain.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } ctl_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_ROOT = 2'd1;
  localparam logic [1:0] STAT_FLAT    = 2'd2;

  // Result width and the quotient bits worked out by the divider chain.
  localparam int OUT_W  = 32;
  localparam int Q_BITS = OUT_W + 1;

endpackage

// ----- src/cubic_peak_interpolator.sv -----
// Path: stages 1 to 3, the square-root cells, stages 4 and 5, the divider cells, the output register.
// Throughput: one transaction per cycle; busy is always low, the pipeline never stalls.
// Each result shows for one cycle under out_valid; the receiver cannot stall it.
// Reset (rst_n low, synchronous) clears every valid flag along the chain; the data
// registers are not reset and the block holds no state between transactions.
module cubic_peak_interpolator #(
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [SAMPLE_BITS-1:0]              in_sample_0,
  input  logic [SAMPLE_BITS-1:0]              in_sample_1,
  input  logic [SAMPLE_BITS-1:0]              in_sample_2,
  input  logic [SAMPLE_BITS-1:0]              in_sample_3,
  output logic                                out_valid,
  output logic signed [cpi_pkg::OUT_W-1:0]    out_peak_position,
  output logic [1:0]                          out_status
);
  import cpi_pkg::*;

  // Coefficient widths: A, B and C scaled by 6 stay below 2^(SAMPLE_BITS+6).
  localparam int BW   = SAMPLE_BITS + 7;        // signed A, B, C
  localparam int MW   = SAMPLE_BITS + 6;        // |B|, |C|
  localparam int DMW  = SAMPLE_BITS + 4;        // |3A|
  localparam int PW   = DMW + MW;               // |3A*C|
  localparam int EW   = 2 * MW + 1;             // discriminant
  localparam int NC   = MW + FRACTION_BITS + 1; // root bits = sqrt cells
  localparam int RW   = 2 * NC;                 // radicand bits
  localparam int NMW  = MW + FRACTION_BITS + 2; // |N|
  localparam int NUMW = NMW + 2;                // 2|N| + |3A|
  localparam int DW   = DMW + 1;                // divisor 2|3A|
  localparam int XW   = NUMW + Q_BITS;
  localparam int STW  = MW + DMW + 2;           // tag along the root chain
  localparam int DTW  = 2;                      // tag along the divider chain
  localparam int LAT  = NC + Q_BITS + 6;
  localparam logic signed [OUT_W-1:0] NEG_ONE = -(OUT_W'(1) << FRACTION_BITS);
  localparam logic [Q_BITS-1:0] MAX_POS = Q_BITS'(33'h0_7FFF_FFFF);
  localparam logic [Q_BITS-1:0] MAX_NEG = Q_BITS'(33'h0_8000_0000);

  // The block never refuses a transaction.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: cubic coefficients, exact and scaled by 6.
  // ---------------------------------------------------------------------
  ctl_t                 ctl1_r;
  logic signed [BW-1:0] a_r, b_r, c_r;
  logic signed [BW-1:0] y0, y1, y2, y3;

  always_comb begin
    y0 = $signed({{(BW-SAMPLE_BITS){1'b0}}, in_sample_0});
    y1 = $signed({{(BW-SAMPLE_BITS){1'b0}}, in_sample_1});
    y2 = $signed({{(BW-SAMPLE_BITS){1'b0}}, in_sample_2});
    y3 = $signed({{(BW-SAMPLE_BITS){1'b0}}, in_sample_3});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= '{valid: start, status: STAT_OK};
    end
  end

  always_ff @(posedge clk) begin
    a_r <= BW'(-y0 + 3 * y1 - 3 * y2 + y3);
    b_r <= BW'(6 * y0 - 15 * y1 + 12 * y2 - 3 * y3);
    c_r <= BW'(-11 * y0 + 18 * y1 - 9 * y2 + 2 * y3);
  end

  // ---------------------------------------------------------------------
  // Stage 2: magnitudes and the two products B*B and |3A|*|C|.
  // ---------------------------------------------------------------------
  ctl_t              ctl2_r;
  logic [2*MW-1:0]   bsq_r;
  logic [PW-1:0]     prod_r;
  logic              prod_neg2_r;
  logic [MW-1:0]     bm2_r;
  logic [DMW-1:0]    dm2_r;
  logic              a_neg2_r, b_neg2_r;
  logic signed [BW-1:0] a3;
  logic [BW-1:0]     bm_full, cm_full, dm_full;

  always_comb begin
    a3      = BW'(3 * a_r);
    bm_full = b_r[BW-1] ? BW'(-b_r) : BW'(b_r);
    cm_full = c_r[BW-1] ? BW'(-c_r) : BW'(c_r);
    dm_full = a3[BW-1]  ? BW'(-a3)  : BW'(a3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r.valid  <= ctl1_r.valid;
      // Flag a flat leading coefficient: no cubic extremum to find.
      ctl2_r.status <= (a_r == '0) ? STAT_FLAT : STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    bsq_r       <= bm_full[MW-1:0] * bm_full[MW-1:0];
    prod_r      <= dm_full[DMW-1:0] * cm_full[MW-1:0];
    prod_neg2_r <= a_r[BW-1] != c_r[BW-1];
    bm2_r       <= bm_full[MW-1:0];
    dm2_r       <= dm_full[DMW-1:0];
    a_neg2_r    <= a_r[BW-1];
    b_neg2_r    <= b_r[BW-1];
  end

  // ---------------------------------------------------------------------
  // Stage 3: discriminant E = B*B - 3AC and the radicand E << 2F.
  // ---------------------------------------------------------------------
  ctl_t            ctl3_r;
  logic [RW-1:0]   rad3_r;
  logic [STW-1:0]  tag3_r;
  logic            pneg;
  logic [EW-1:0]   e_val;
  logic            e_low;

  always_comb begin
    pneg  = prod_neg2_r && (prod_r != '0);
    e_low = !pneg && (bsq_r < (2*MW)'(prod_r));
    if (pneg) begin
      e_val = EW'(bsq_r) + EW'(prod_r);
    end else begin
      e_val = EW'(bsq_r) - EW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r.valid <= ctl2_r.valid;
      // A flat cubic outranks a negative discriminant.
      if (ctl2_r.status == STAT_FLAT) begin
        ctl3_r.status <= STAT_FLAT;
      end else if (e_low) begin
        ctl3_r.status <= STAT_NO_ROOT;
      end else begin
        ctl3_r.status <= STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad3_r <= RW'({e_val, {(2*FRACTION_BITS){1'b0}}});
    tag3_r <= {bm2_r, dm2_r, a_neg2_r, b_neg2_r};
  end

  // ---------------------------------------------------------------------
  // Square-root chain: each cell settles one root bit from two radicand bits.
  // ---------------------------------------------------------------------
  ctl_t           sq_ctl  [NC+1];
  logic [NC:0]    sq_rem  [NC+1];
  logic [NC-1:0]  sq_root [NC+1];
  logic [RW-1:0]  sq_rad  [NC+1];
  logic [STW-1:0] sq_tag  [NC+1];

  assign sq_ctl[0]  = ctl3_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = rad3_r;
  assign sq_tag[0]  = tag3_r;

  for (genvar i = 0; i < NC; i++) begin : g_sqrt
    cpi_sqrt_cell #(
      .RootW (NC),
      .RadW  (RW),
      .TagW  (STW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (sq_ctl[i]),
      .rem_in  (sq_rem[i]),
      .root_in (sq_root[i]),
      .rad_in  (sq_rad[i]),
      .tag_in  (sq_tag[i]),
      .ctl_r   (sq_ctl[i+1]),
      .rem_r   (sq_rem[i+1]),
      .root_r  (sq_root[i+1]),
      .rad_r   (sq_rad[i+1]),
      .tag_r   (sq_tag[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 4: N = -(B << F) - S as sign and magnitude.
  // ---------------------------------------------------------------------
  ctl_t            ctl4_r;
  logic [NMW-1:0]  nm4_r;
  logic            qneg4_r;
  logic [DMW-1:0]  dm4_r;
  logic [MW-1:0]   bm_t;
  logic [DMW-1:0]  dm_t;
  logic            a_neg_t, b_neg_t;
  logic [NMW-1:0]  bs_x, s_x, nm_v;
  logic            nneg_v;

  always_comb begin
    {bm_t, dm_t, a_neg_t, b_neg_t} = sq_tag[NC];
    bs_x = NMW'({bm_t, {FRACTION_BITS{1'b0}}});
    s_x  = NMW'(sq_root[NC]);
    if (b_neg_t) begin
      if (bs_x >= s_x) begin
        nm_v   = bs_x - s_x;
        nneg_v = 1'b0;
      end else begin
        nm_v   = s_x - bs_x;
        nneg_v = 1'b1;
      end
    end else begin
      nm_v   = bs_x + s_x;
      nneg_v = 1'b1;
    end
    if (nm_v == '0) begin
      nneg_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
    end else begin
      ctl4_r <= sq_ctl[NC];
    end
  end

  always_ff @(posedge clk) begin
    nm4_r   <= nm_v;
    qneg4_r <= nneg_v != a_neg_t;
    dm4_r   <= dm_t;
  end

  // ---------------------------------------------------------------------
  // Stage 5: rounded quotient setup (2|N| + |3A|) / (2|3A|).
  // Numerator bits above the quotient width either saturate the result
  // or seed the divider remainder.
  // ---------------------------------------------------------------------
  ctl_t              ctl5_r;
  logic [DW-1:0]     rem5_r, den5_r;
  logic [Q_BITS-1:0] num5_r;
  logic [DTW-1:0]    tag5_r;
  logic [NUMW-1:0]   num_v;
  logic [XW-1:0]     num_x;
  logic [NUMW-1:0]   upper;
  logic [DW-1:0]     den_v;
  logic              sat_v;

  always_comb begin
    num_v = NUMW'({nm4_r, 1'b0}) + NUMW'(dm4_r);
    den_v = {dm4_r, 1'b0};
    num_x = XW'(num_v);
    upper = num_x[XW-1:Q_BITS];
    sat_v = upper >= NUMW'(den_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else begin
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    rem5_r <= upper[DW-1:0];
    den5_r <= den_v;
    num5_r <= num_x[Q_BITS-1:0];
    tag5_r <= {sat_v, qneg4_r};
  end

  // ---------------------------------------------------------------------
  // Divider chain: one quotient bit per cell.
  // ---------------------------------------------------------------------
  ctl_t              dv_ctl [Q_BITS+1];
  logic [DW-1:0]     dv_rem [Q_BITS+1];
  logic [DW-1:0]     dv_den [Q_BITS+1];
  logic [Q_BITS-1:0] dv_num [Q_BITS+1];
  logic [Q_BITS-1:0] dv_quo [Q_BITS+1];
  logic [DTW-1:0]    dv_tag [Q_BITS+1];

  assign dv_ctl[0] = ctl5_r;
  assign dv_rem[0] = rem5_r;
  assign dv_den[0] = den5_r;
  assign dv_num[0] = num5_r;
  assign dv_quo[0] = '0;
  assign dv_tag[0] = tag5_r;

  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    cpi_div_cell #(
      .DivW (DW),
      .TagW (DTW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_in (dv_ctl[j]),
      .rem_in (dv_rem[j]),
      .den_in (dv_den[j]),
      .num_in (dv_num[j]),
      .quo_in (dv_quo[j]),
      .tag_in (dv_tag[j]),
      .ctl_r  (dv_ctl[j+1]),
      .rem_r  (dv_rem[j+1]),
      .den_r  (dv_den[j+1]),
      .num_r  (dv_num[j+1]),
      .quo_r  (dv_quo[j+1]),
      .tag_r  (dv_tag[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output stage: apply sign, saturate, substitute the special cases.
  // ---------------------------------------------------------------------
  logic                       sat_f, qneg_f;
  logic [Q_BITS-1:0]          q_f;
  logic signed [OUT_W-1:0]    pos_f;
  logic                       out_valid_r;
  logic signed [OUT_W-1:0]    out_pos_r;
  logic [1:0]                 out_status_r;

  always_comb begin
    {sat_f, qneg_f} = dv_tag[Q_BITS];
    q_f = dv_quo[Q_BITS];
    if (qneg_f) begin
      if (sat_f || (q_f > MAX_NEG)) begin
        pos_f = $signed(MAX_NEG[OUT_W-1:0]);
      end else begin
        pos_f = OUT_W'(-q_f);
      end
    end else begin
      if (sat_f || (q_f > MAX_POS)) begin
        pos_f = $signed(MAX_POS[OUT_W-1:0]);
      end else begin
        pos_f = $signed(q_f[OUT_W-1:0]);
      end
    end
    case (dv_ctl[Q_BITS].status)
      STAT_NO_ROOT: pos_f = NEG_ONE;
      STAT_FLAT:    pos_f = '0;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_ctl[Q_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r    <= pos_f;
    out_status_r <= dv_ctl[Q_BITS].status;
  end

  assign out_valid         = out_valid_r;
  assign out_peak_position = out_pos_r;
  assign out_status        = out_status_r;

`ifndef NO_ASSERTIONS
  // Every result traces back to a start that entered the pipeline.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching transaction");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_NO_ROOT ||
                   out_status == STAT_FLAT))
    else $error("undefined status code");

  a_no_root_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_NO_ROOT) |-> out_peak_position == NEG_ONE)
    else $error("no-root result must read -1.0");

  a_flat_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FLAT) |-> out_peak_position == '0)
    else $error("flat result must read zero");
`endif

endmodule

// ----- src/cpi_sqrt_cell.sv -----
module cpi_sqrt_cell #(
  parameter int RootW = 8,
  parameter int RadW  = 16,
  parameter int TagW  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpi_pkg::ctl_t       ctl_in,
  input  logic [RootW:0]      rem_in,
  input  logic [RootW-1:0]    root_in,
  input  logic [RadW-1:0]     rad_in,
  input  logic [TagW-1:0]     tag_in,
  output cpi_pkg::ctl_t       ctl_r,
  output logic [RootW:0]      rem_r,
  output logic [RootW-1:0]    root_r,
  output logic [RadW-1:0]     rad_r,
  output logic [TagW-1:0]     tag_r
);
  import cpi_pkg::*;

  logic [RootW+2:0] rem2;
  logic [RootW+2:0] trial;
  logic             ge;
  logic [RootW+2:0] diff;

  // Bring down the next two radicand bits and try a one in the next root bit.
  always_comb begin
    rem2  = {rem_in, rad_in[RadW-1 -: 2]};
    trial = {1'b0, root_in, 2'b01};
    ge    = rem2 >= trial;
    diff  = ge ? (rem2 - trial) : rem2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= diff[RootW:0];
    root_r <= {root_in[RootW-2:0], ge};
    rad_r  <= {rad_in[RadW-3:0], 2'b00};
    tag_r  <= tag_in;
  end

endmodule

// ----- src/cpi_div_cell.sv -----
module cpi_div_cell #(
  parameter int DivW = 8,
  parameter int TagW = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cpi_pkg::ctl_t               ctl_in,
  input  logic [DivW-1:0]             rem_in,
  input  logic [DivW-1:0]             den_in,
  input  logic [cpi_pkg::Q_BITS-1:0]  num_in,
  input  logic [cpi_pkg::Q_BITS-1:0]  quo_in,
  input  logic [TagW-1:0]             tag_in,
  output cpi_pkg::ctl_t               ctl_r,
  output logic [DivW-1:0]             rem_r,
  output logic [DivW-1:0]             den_r,
  output logic [cpi_pkg::Q_BITS-1:0]  num_r,
  output logic [cpi_pkg::Q_BITS-1:0]  quo_r,
  output logic [TagW-1:0]             tag_r
);
  import cpi_pkg::*;

  logic [DivW:0] rem2;
  logic          ge;
  logic [DivW:0] diff;

  // Shift in one numerator bit and subtract the divisor where it fits.
  always_comb begin
    rem2 = {rem_in, num_in[Q_BITS-1]};
    ge   = rem2 >= {1'b0, den_in};
    diff = ge ? (rem2 - {1'b0, den_in}) : rem2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= diff[DivW-1:0];
    den_r <= den_in;
    num_r <= {num_in[Q_BITS-2:0], 1'b0};
    quo_r <= {quo_in[Q_BITS-2:0], ge};
    tag_r <= tag_in;
  end

endmodule

// ----- tb/sv/cubic_peak_interpolator_tb.sv -----
`timescale 1ns / 1ps

module cubic_peak_interpolator_tb;
  import cpi_pkg::*;

  localparam int SB = 24;
  localparam int FB = 16;
  localparam int LATENCY = SB + FB + 46;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;

  typedef struct {
    logic signed [31:0] peak;
    logic [1:0]         status;
  } peak_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [SB-1:0] in_sample_0 = '0;
  logic [SB-1:0] in_sample_1 = '0;
  logic [SB-1:0] in_sample_2 = '0;
  logic [SB-1:0] in_sample_3 = '0;
  logic          out_valid;
  logic signed [31:0] out_peak_position;
  logic [1:0]    out_status;

  peak_result_t  expected_peaks[$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            idle_pct = 25;

  cubic_peak_interpolator #(.SAMPLE_BITS(SB), .FRACTION_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_0(in_sample_0), .in_sample_1(in_sample_1),
    .in_sample_2(in_sample_2), .in_sample_3(in_sample_3),
    .out_valid(out_valid), .out_peak_position(out_peak_position),
    .out_status(out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predict the peak position: exact integer cubic coefficients scaled by 6,
  // exact floor square root, then a rounded (ties away from zero) division.
  function automatic peak_result_t predict_peak(logic [SB-1:0] s0, logic [SB-1:0] s1,
                                                logic [SB-1:0] s2, logic [SB-1:0] s3);
    peak_result_t r;
    logic signed [63:0] y0, y1, y2, y3, a, b, c;
    logic signed [159:0] disc;
    logic [159:0] scaled, root, trial;
    logic signed [159:0] numer, denom;
    logic [159:0] nmag, dmag, q;
    logic qneg;
    y0 = 64'(s0); y1 = 64'(s1); y2 = 64'(s2); y3 = 64'(s3);
    a = -y0 + 3 * y1 - 3 * y2 + y3;
    b = 6 * y0 - 15 * y1 + 12 * y2 - 3 * y3;
    c = -11 * y0 + 18 * y1 - 9 * y2 + 2 * y3;
    r.peak = '0;
    if (a == 0) begin
      r.status = STAT_FLAT;
      return r;
    end
    disc = 160'(b) * 160'(b) - 160'(3) * 160'(a) * 160'(c);
    if (disc < 0) begin
      r.status = STAT_NO_ROOT;
      r.peak = -(32'sd1 <<< FB);
      return r;
    end
    scaled = 160'(disc) << (2 * FB);
    root = '0;
    for (int k = 79; k >= 0; k--) begin
      trial = root | (160'(1) << k);
      if (trial * trial <= scaled) root = trial;
    end
    numer = -(160'(b) <<< FB) - $signed(root);
    denom = 160'(3) * 160'(a);
    nmag = numer < 0 ? -numer : numer;
    dmag = denom < 0 ? -denom : denom;
    q = (2 * nmag + dmag) / (2 * dmag);
    qneg = (numer < 0) != (denom < 0) && nmag != 0;
    if (qneg) r.peak = (q > 160'h8000_0000) ? 32'sh8000_0000 : -$signed(32'(q));
    else r.peak = (q > 160'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
    r.status = STAT_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Append one prediction at the tail of the expected queue.
  task automatic enqueue_expected(peak_result_t p);
    expected_peaks.insert(expected_peaks.size(), p);
  endtask

  // Send one transaction; idle at random before it according to idle_pct.
  // Start stays high afterwards so the next transaction can follow at once.
  task automatic send_samples(logic [SB-1:0] s0, logic [SB-1:0] s1,
                              logic [SB-1:0] s2, logic [SB-1:0] s3);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_sample_0 <= s0; in_sample_1 <= s1; in_sample_2 <= s2; in_sample_3 <= s3;
    @(posedge clk);
    while (busy) @(posedge clk);
    enqueue_expected(predict_peak(s0, s1, s2, s3));
    @(negedge clk);
  endtask

  // Check every result against the oldest prediction.
  always @(posedge clk) begin
    peak_result_t want;
    if (rst_n && out_valid) begin
      if (expected_peaks.size() == 0) begin
        report_mismatch("unexpected result", out_peak_position, 0);
      end else begin
        want = expected_peaks.pop_front();
        if (out_peak_position !== want.peak)
          report_mismatch("peak_position", out_peak_position, want.peak);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
      end
    end
  end

  // Watchdog: count cycles with no transaction accepted on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drop start and hold until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_peaks.size() != 0) @(negedge clk);
  endtask

  // Extremes, flat and degenerate cases, ordinary peaks.
  task automatic test_directed();
    logic [SB-1:0] mx;
    mx = '1;
    send_samples(0, 0, 0, 0);                 // zero leading coefficient
    send_samples(mx, mx, mx, mx);
    send_samples(1, 2, 3, 4);                 // line: flat cubic term
    send_samples(0, 1, 1, 0);                 // parabola: A == 0
    send_samples(0, mx, mx, 0);
    send_samples(0, 10, 11, 0);               // ordinary peak
    send_samples(0, mx, 0, 0);
    send_samples(0, 0, mx, 0);
    send_samples(mx, 0, 0, 0);
    send_samples(0, 0, 0, mx);                // large cubic with roots at 0, 1 and 2
    send_samples(mx, 0, mx, 0);
    send_samples(0, mx, 0, mx);
    send_samples(0, 0, 0, 1);                 // cubic with roots at 0, 1 and 2, two extrema
    send_samples(1, 0, 0, 0);
    send_samples(0, 1, 0, 0);
    send_samples(0, 0, 1, 0);
    send_samples(mx, mx - 1, 0, mx);          // large samples, peak between 0 and 1
    send_samples(0, 0, 1, 3);                 // flat: A == 0
    send_samples(mx, 1, mx, 1);
    send_samples(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    wait_drained();
  endtask

  // Random items, mostly peaks in the middle, some fully random noise.
  task automatic test_random(int count);
    logic [SB-1:0] v[4];
    int w;
    for (int n = 0; n < count; n++) begin
      idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 25;
      w = $urandom_range(SB, 1);
      for (int k = 0; k < 4; k++) v[k] = SB'($urandom() & ((1 << w) - 1));
      if ($urandom_range(3) != 0) begin
        // shape a hump: middle samples above the outer ones
        if (v[1] < v[0]) v[1] = v[0];
        if (v[2] < v[3]) v[2] = v[3];
      end
      if ($urandom_range(19) == 0) v[2'($urandom_range(3))] = '1;
      send_samples(v[0], v[1], v[2], v[3]);
      if (n == count / 2) wait_drained();   // sender holds off until all is back
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1230);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_peaks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cpi_pkg.sv
src/cpi_sqrt_cell.sv
src/cpi_div_cell.sv
src/cubic_peak_interpolator.sv
tb/sv/cubic_peak_interpolator_tb.sv
